// ===== sv/ddsp_pkg.sv =====
// Shared types, constants and the power-of-ten table for the digit splitter.
`timescale 1ns / 1ps

package ddsp_pkg;

    // Defaults and fixed field widths
    localparam int MAX_DIGITS_DEF = 16;
    localparam int READING_W      = 64;
    localparam int FRAC_W         = 16;
    localparam int HALF_W         = READING_W / 2;
    localparam int MULT_W         = 24;                  // holds 10^7
    localparam int PROD_W         = HALF_W + MULT_W;
    localparam int SUM_W          = PROD_W + HALF_W;
    localparam int COUNT_W        = 5;
    localparam int PLACES_W       = 3;
    localparam int CODE_W         = 4;
    localparam int POS_W          = 4;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 5;

    // Double-dabble converter: enough BCD cells for any 64-bit value
    localparam int BCD_CELLS      = 20;
    localparam int STEP_BITS      = 4;                   // bits shifted in per step
    localparam int CONV_STEPS     = READING_W / STEP_BITS;
    localparam int STEP_CNT_W     = $clog2(CONV_STEPS);

    localparam logic [SUM_W-1:0]  ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);
    localparam logic [CODE_W-1:0] TUBE_BLANK = 4'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DIGIT_COUNT    = 2'd0,
        REG_SHOW_ZEROS     = 2'd1,
        REG_DECIMAL_PLACES = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  digit_count;
        logic                show_leading_zeros;
        logic [PLACES_W-1:0] decimal_places;
    } cfg_t;

    typedef struct packed {
        logic                 has_value;
        logic [READING_W-1:0] reading;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [CODE_W-1:0] tube_code;
        logic              overflowed;
        logic              last_digit;
    } out_item_t;

    // Scaled reading handed to the converter
    typedef struct packed {
        logic                 has_value;
        logic                 wide_ovf;
        logic [READING_W-1:0] value;
    } scaled_t;

    // Finished BCD digits handed to the emitter, cell 0 least significant
    typedef struct packed {
        logic                              has_value;
        logic                              wide_ovf;
        logic [BCD_CELLS-1:0][CODE_W-1:0]  digits;
    } bcd_t;

    function automatic logic [MULT_W-1:0] pow10(input logic [PLACES_W-1:0] places);
        logic [MULT_W-1:0] m;
        unique case (places)
            3'd0:    m = 24'd1;
            3'd1:    m = 24'd10;
            3'd2:    m = 24'd100;
            3'd3:    m = 24'd1000;
            3'd4:    m = 24'd10000;
            3'd5:    m = 24'd100000;
            3'd6:    m = 24'd1000000;
            default: m = 24'd10000000;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/ddsp_scale.sv =====
// Two-stage scaler: partial products by 10^places, then round and shift out the fraction.
`timescale 1ns / 1ps

module ddsp_scale (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  ddsp_pkg::in_item_t        in_item,
    input  logic [ddsp_pkg::PLACES_W-1:0] places,
    output logic                      out_valid,
    input  logic                      out_ready,
    output ddsp_pkg::scaled_t         out_item
);

    logic                          a_valid_reg, a_valid_next;
    logic                          a_has_reg, a_has_next;
    logic [ddsp_pkg::PROD_W-1:0]   lo_reg, lo_next;
    logic [ddsp_pkg::PROD_W-1:0]   hi_reg, hi_next;
    logic                          b_valid_reg, b_valid_next;
    ddsp_pkg::scaled_t             b_reg, b_next;
    logic [ddsp_pkg::MULT_W-1:0]   mult;
    logic [ddsp_pkg::SUM_W-1:0]    sum;
    logic                          a_take, b_take;

    assign b_take   = !b_valid_reg || out_ready;
    assign a_take   = !a_valid_reg || b_take;
    assign in_ready = a_take;
    assign mult     = ddsp_pkg::pow10(places);

    // full sum = hi * 2^32 + lo + 2^15; bits above the 64-bit window mean overflow
    assign sum = {hi_reg, {ddsp_pkg::HALF_W{1'b0}}}
               + ddsp_pkg::SUM_W'(lo_reg)
               + ddsp_pkg::ROUND_HALF;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        a_has_next   = a_has_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        if (a_take)
        begin
            a_valid_next = in_valid;
            a_has_next   = in_item.has_value;
            lo_next      = {{ddsp_pkg::MULT_W{1'b0}}, in_item.reading[ddsp_pkg::HALF_W-1:0]}
                         * {{ddsp_pkg::HALF_W{1'b0}}, mult};
            hi_next      = {{ddsp_pkg::MULT_W{1'b0}},
                            in_item.reading[ddsp_pkg::READING_W-1:ddsp_pkg::HALF_W]}
                         * {{ddsp_pkg::HALF_W{1'b0}}, mult};
        end
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        b_next       = b_reg;
        if (b_take)
        begin
            b_valid_next     = a_valid_reg;
            b_next.has_value = a_has_reg;
            b_next.value     = sum[ddsp_pkg::FRAC_W +: ddsp_pkg::READING_W];
            b_next.wide_ovf  = |sum[ddsp_pkg::SUM_W-1:ddsp_pkg::FRAC_W+ddsp_pkg::READING_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_has_reg <= a_has_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        b_reg     <= b_next;
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_reg;

endmodule

// ===== sv/ddsp_cell.sv =====
// One BCD digit cell of the double-dabble chain, four add-3/shift steps per cycle.
`timescale 1ns / 1ps

module ddsp_cell (
    input  logic                            clk,
    input  logic                            clear,
    input  logic                            step,
    input  logic [ddsp_pkg::STEP_BITS-1:0]  in_bits,   // msb enters first
    output logic [ddsp_pkg::STEP_BITS-1:0]  out_bits,  // to next higher cell
    output logic [ddsp_pkg::CODE_W-1:0]     stepped    // digit after this step
);

    logic [ddsp_pkg::CODE_W-1:0] digit_reg, digit_next;

    always_comb
    begin
        logic [ddsp_pkg::CODE_W-1:0] d;
        d        = digit_reg;
        out_bits = '0;
        for (int s = 0; s < ddsp_pkg::STEP_BITS; s++)
        begin
            if (d >= 4'd5)
                d = d + 4'd3;
            out_bits[ddsp_pkg::STEP_BITS-1-s] = d[ddsp_pkg::CODE_W-1];
            d = {d[ddsp_pkg::CODE_W-2:0], in_bits[ddsp_pkg::STEP_BITS-1-s]};
        end
        stepped = d;
    end

    always_comb
    begin
        if (clear)
            digit_next = '0;
        else if (step)
            digit_next = stepped;
        else
            digit_next = digit_reg;
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

// ===== sv/ddsp_conv.sv =====
// Binary to BCD converter: a row of digit cells fed four bits a step from a shift register.
`timescale 1ns / 1ps

module ddsp_conv (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ddsp_pkg::scaled_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output ddsp_pkg::bcd_t    out_item
);

    logic                                 valid_reg, valid_next;
    logic [ddsp_pkg::STEP_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ddsp_pkg::READING_W-1:0]       bin_reg, bin_next;
    logic                                 has_reg, has_next;
    logic                                 wovf_reg, wovf_next;
    logic                                 last_step, hand, load, step;
    logic [ddsp_pkg::STEP_BITS-1:0]       chain [ddsp_pkg::BCD_CELLS];
    logic [ddsp_pkg::BCD_CELLS-1:0][ddsp_pkg::CODE_W-1:0] stepped;

    assign last_step = (cnt_reg == ddsp_pkg::STEP_CNT_W'(ddsp_pkg::CONV_STEPS - 1));
    // final step and hand-off happen together; hold if the emitter is still busy
    assign hand      = valid_reg && last_step && out_ready;
    assign step      = valid_reg && (!last_step || out_ready);
    assign in_ready  = !valid_reg || hand;
    assign load      = in_valid && in_ready;

    assign chain[0] = bin_reg[ddsp_pkg::READING_W-1 -: ddsp_pkg::STEP_BITS];

    for (genvar j = 0; j < ddsp_pkg::BCD_CELLS; j++)
    begin : g_cell
        if (j < ddsp_pkg::BCD_CELLS - 1)
        begin : g_mid
            ddsp_cell u_cell (
                .clk      (clk),
                .clear    (load),
                .step     (step),
                .in_bits  (chain[j]),
                .out_bits (chain[j+1]),
                .stepped  (stepped[j])
            );
        end
        else
        begin : g_top
            // top cell never carries out: 20 digits cover 64 bits
            ddsp_cell u_cell (
                .clk      (clk),
                .clear    (load),
                .step     (step),
                .in_bits  (chain[j]),
                .out_bits (),
                .stepped  (stepped[j])
            );
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        bin_next   = bin_reg;
        has_next   = has_reg;
        wovf_next  = wovf_reg;
        if (hand)
            valid_next = 1'b0;
        if (step)
        begin
            cnt_next = cnt_reg + 1'b1;
            bin_next = bin_reg << ddsp_pkg::STEP_BITS;
        end
        if (load)
        begin
            valid_next = 1'b1;
            cnt_next   = '0;
            bin_next   = in_item.value;
            has_next   = in_item.has_value;
            wovf_next  = in_item.wide_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        has_reg  <= has_next;
        wovf_reg <= wovf_next;
    end

    assign out_valid          = hand;
    assign out_item.has_value = has_reg;
    assign out_item.wide_ovf  = wovf_reg;
    assign out_item.digits    = stepped;

endmodule

// ===== sv/ddsp_emit.sv =====
// Digit emitter: overflow check, one tube code a cycle, leading-zero blanking.
`timescale 1ns / 1ps

module ddsp_emit #(
    parameter int MAX_DIGITS = ddsp_pkg::MAX_DIGITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ddsp_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  ddsp_pkg::bcd_t      in_item,
    output logic                result_valid,
    output ddsp_pkg::out_item_t result
);

    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic [ddsp_pkg::CODE_W-1:0]   digit_reg [MAX_DIGITS];
    logic                          active_reg, active_next;
    logic [IW-1:0]                 idx_reg, idx_next;     // digit index, counts down
    logic [IW-1:0]                 pos_reg, pos_next;     // tube position, counts up
    logic                          has_reg, has_next;
    logic                          ovf_reg, ovf_next;
    logic                          hz_reg, hz_next;       // all higher digits zero
    logic                          out_valid_reg, out_valid_next;
    ddsp_pkg::out_item_t           out_reg, out_next;
    logic [ddsp_pkg::COUNT_W-1:0]  eff_count;
    logic                          in_ovf;
    logic                          load, last;
    logic [ddsp_pkg::CODE_W-1:0]   cur, code;

    always_comb
    begin
        if (cfg.digit_count == '0)
            eff_count = ddsp_pkg::COUNT_W'(1);
        else if (cfg.digit_count > ddsp_pkg::COUNT_W'(MAX_DIGITS))
            eff_count = ddsp_pkg::COUNT_W'(MAX_DIGITS);
        else
            eff_count = cfg.digit_count;
    end

    // any nonzero digit above the shown ones means the value does not fit
    always_comb
    begin
        in_ovf = in_item.wide_ovf;
        for (int k = 0; k < ddsp_pkg::BCD_CELLS; k++)
        begin
            if ((ddsp_pkg::COUNT_W'(k) >= eff_count) && (in_item.digits[k] != '0))
                in_ovf = 1'b1;
        end
        in_ovf = in_ovf && in_item.has_value;
    end

    assign last     = (idx_reg == '0);
    assign in_ready = !active_reg || last;
    assign load     = in_valid && in_ready;
    assign cur      = digit_reg[idx_reg];

    always_comb
    begin
        priority if (!has_reg || ovf_reg)
            code = ddsp_pkg::TUBE_BLANK;
        else if ((cur == '0) && !last && hz_reg && !cfg.show_leading_zeros)
            code = ddsp_pkg::TUBE_BLANK;
        else
            code = cur;
    end

    always_comb
    begin
        active_next    = active_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        has_next       = has_reg;
        ovf_next       = ovf_reg;
        hz_next        = hz_reg;
        out_valid_next = active_reg;
        out_next       = out_reg;
        if (active_reg)
        begin
            out_next.position   = ddsp_pkg::POS_W'(pos_reg);
            out_next.tube_code  = code;
            out_next.overflowed = ovf_reg;
            out_next.last_digit = last;
            idx_next            = idx_reg - 1'b1;
            pos_next            = pos_reg + 1'b1;
            hz_next             = hz_reg && (cur == '0);
            if (last)
                active_next = 1'b0;
        end
        if (load)
        begin
            active_next = 1'b1;
            idx_next    = IW'(eff_count - 1'b1);
            pos_next    = '0;
            has_next    = in_item.has_value;
            ovf_next    = in_ovf;
            hz_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        has_reg <= has_next;
        ovf_reg <= ovf_next;
        hz_reg  <= hz_next;
        out_reg <= out_next;
        if (load)
        begin
            for (int k = 0; k < MAX_DIGITS; k++)
                digit_reg[k] <= in_item.digits[k];
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== sv/decimal_digit_display_splitter_top.sv =====
// Top level of the decimal digit display splitter: config registers, scaler, converter, emitter.
`timescale 1ns / 1ps

// Channel    Handshake               Payload                      Notes
// ---------  ----------------------  ---------------------------  --------------------------
// operand    start / busy            in_item_t (has_value,        taken when start && !busy
//                                    reading Q48.16)
// result     result_valid strobe     out_item_t (position,        one cycle each, no stall
//                                    tube_code, overflowed,
//                                    last_digit)
// cfg        cfg_valid / cfg_ready   cfg_index, cfg_data          ready always high
//
// Path: two scaling stages (partial products, then round), then the double-dabble cell
// row (4 bits a step), then the emitter's output register; from there the tubes of an
// item follow on consecutive cycles.
// The cell row takes 16 steps per item and the emitter shows one tube a cycle; new
// readings are taken while earlier ones are still in flight. Up to four items are in
// flight: two in the scaler, one in the cell row, one in the emitter.
// Reset clears the pipeline valids and loads the register defaults (1 digit, blanking on,
// no decimal places). The receiver cannot stall. With up to 16 tubes the emitter is always
// free when the cell row hands over, so busy rises only once both scaler stages hold items
// while the cell row is still converting.

module decimal_digit_display_splitter_top #(
    parameter int MAX_DIGITS = ddsp_pkg::MAX_DIGITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ddsp_pkg::in_item_t                  operand,
    output logic                                result_valid,
    output ddsp_pkg::out_item_t                 result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ddsp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ddsp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ddsp_pkg::cfg_t     cfg_reg, cfg_next;
    logic               scale_ready;
    logic               scaled_valid, conv_ready;
    ddsp_pkg::scaled_t  scaled;
    logic               bcd_valid, emit_ready;
    ddsp_pkg::bcd_t     bcd;

    // Config registers; writes must be issued only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (ddsp_pkg::cfg_reg_t'(cfg_index))
                ddsp_pkg::REG_DIGIT_COUNT:
                    cfg_next.digit_count = cfg_data[ddsp_pkg::COUNT_W-1:0];
                ddsp_pkg::REG_SHOW_ZEROS:
                    cfg_next.show_leading_zeros = cfg_data[0];
                ddsp_pkg::REG_DECIMAL_PLACES:
                    cfg_next.decimal_places = cfg_data[ddsp_pkg::PLACES_W-1:0];
                default:
                    cfg_next = cfg_reg;     // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.digit_count        <= ddsp_pkg::COUNT_W'(1);
            cfg_reg.show_leading_zeros <= 1'b0;
            cfg_reg.decimal_places     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: reading * 10^places, rounded half up, fraction dropped
    ddsp_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .in_ready  (scale_ready),
        .in_item   (operand),
        .places    (cfg_reg.decimal_places),
        .out_valid (scaled_valid),
        .out_ready (conv_ready),
        .out_item  (scaled)
    );

    assign busy = !scale_ready;

    // Row of BCD cells; hands all 20 digits over on its final step
    ddsp_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scaled_valid),
        .in_ready  (conv_ready),
        .in_item   (scaled),
        .out_valid (bcd_valid),
        .out_ready (emit_ready),
        .out_item  (bcd)
    );

    // Serializer: one tube per cycle, leftmost first
    ddsp_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (bcd_valid),
        .in_ready     (emit_ready),
        .in_item      (bcd),
        .result_valid (result_valid),
        .result       (result)
    );

    // An overflowed display is all blank
    a_ovf_blank: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.overflowed |-> result.tube_code == ddsp_pkg::TUBE_BLANK)
        else $error("overflowed result shows a digit");

    // Tube codes stay within digits and blank
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.tube_code <= ddsp_pkg::TUBE_BLANK)
        else $error("tube code out of range");

    // A run continues without gaps until its last digit, positions stepping by one
    a_run_contig: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_digit |=>
            result_valid &&
            (result.position == ddsp_pkg::POS_W'($past(result.position) + 1'b1)))
        else $error("digit run broken");

    // A new run always starts at the leftmost tube
    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_digit |=>
            !result_valid || (result.position == '0))
        else $error("run does not start at position 0");

endmodule

// ===== sim/decimal_digit_display_splitter_top_tb.sv =====
// Self-checking testbench for the digit splitter: directed table, then random readings.
`timescale 1ns / 1ps

module decimal_digit_display_splitter_top_tb;

    // Idle cycles (nothing accepted, no tube, no register write) before giving up
    localparam int STALL_LIMIT = 2000;
    // Drain bound at the end, kept below the watchdog so leftovers get reported
    localparam int DRAIN_LIMIT = 1000;
    // Cycles allowed after the last tube before the verdict
    localparam int TAIL_CYCLES = 40;
    // Cycles allowed after the last tube before a register write
    localparam int SETTLE_CYCLES = 4;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 70;

    // Index that maps to no register; writes there must change nothing
    localparam logic [ddsp_pkg::CFG_INDEX_W-1:0] UNUSED_REG = 2'd3;

    typedef enum bit { ROW_CFG, ROW_ITEM } row_kind_t;

    // One row of the directed table: a register write or a reading.
    // Pinned rows carry an expected code and flag that apply to every tube.
    typedef struct packed {
        row_kind_t                        kind;
        logic [ddsp_pkg::CFG_INDEX_W-1:0] idx;
        logic [ddsp_pkg::CFG_DATA_W-1:0]  data;
        ddsp_pkg::in_item_t               item;
        bit                               pinned;
        logic [ddsp_pkg::CODE_W-1:0]      pin_code;
        bit                               pin_ovf;
    } dir_row_t;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    ddsp_pkg::in_item_t               operand = '0;
    logic                             result_valid;
    ddsp_pkg::out_item_t              result;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [ddsp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ddsp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Shadow copy of the register file, updated on each completed write
    logic [ddsp_pkg::COUNT_W-1:0]  count_sh  = 5'd1;
    logic                          zeros_sh  = 1'b0;
    logic [ddsp_pkg::PLACES_W-1:0] places_sh = 3'd0;

    ddsp_pkg::out_item_t pending_tubes[$];   // tubes still owed by the block, oldest first
    dir_row_t            directed_rows[$];
    int                  errors = 0;
    int                  idle_cycles = 0;

    decimal_digit_display_splitter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operand      (operand),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] ten_pow(input int n);
        logic [63:0] p;
        p = 64'd1;
        repeat (n) p = p * 64'd10;
        return p;
    endfunction

    // Digit count as the block applies it: zero shows one tube, oversize shows all
    function automatic int tubes_shown();
        if (count_sh == 0)
            return 1;
        if (count_sh > 16)
            return 16;
        return int'(count_sh);
    endfunction

    // Scale by 10^places, round half up, split into digits, blank as configured
    function automatic void predict_tubes(input ddsp_pkg::in_item_t it);
        logic [127:0]                wide;
        logic [63:0]                 val;
        logic [ddsp_pkg::CODE_W-1:0] dig [16];
        logic [ddsp_pkg::CODE_W-1:0] code;
        ddsp_pkg::out_item_t         t;
        int                          n;
        bit                          ovf;
        bit                          lead;
        n    = tubes_shown();
        ovf  = 1'b0;
        val  = '0;
        lead = 1'b1;
        if (it.has_value)
        begin
            wide = ({64'd0, it.reading} * {64'd0, ten_pow(int'(places_sh))} + 128'h8000) >> 16;
            if (wide[127:64] != 0)
                ovf = 1'b1;
            else
                val = wide[63:0];
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            dig[i] = 4'(val % 64'd10);
            val    = val / 64'd10;
        end
        // digits left over mean the value does not fit the tubes
        if (it.has_value && val != 0)
            ovf = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (!it.has_value || ovf)
                code = ddsp_pkg::TUBE_BLANK;
            else
            begin
                code = dig[i];
                // leading zero blanking; the rightmost tube always shows its digit
                if (dig[i] == 0 && i != n - 1 && lead && !zeros_sh)
                    code = ddsp_pkg::TUBE_BLANK;
                if (dig[i] != 0)
                    lead = 1'b0;
            end
            t.position   = 4'(i);
            t.tube_code  = code;
            t.overflowed = ovf;
            t.last_digit = (i == n - 1);
            pending_tubes.push_back(t);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    function automatic dir_row_t cfg_row(input logic [ddsp_pkg::CFG_INDEX_W-1:0] idx,
                                         input logic [ddsp_pkg::CFG_DATA_W-1:0] data);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic dir_row_t item_row(input bit has, input logic [63:0] rd);
        dir_row_t r;
        r                = '0;
        r.kind           = ROW_ITEM;
        r.item.has_value = has;
        r.item.reading   = rd;
        return r;
    endfunction

    function automatic dir_row_t pinned_row(input bit has, input logic [63:0] rd,
                                            input logic [ddsp_pkg::CODE_W-1:0] code,
                                            input bit ovf);
        dir_row_t r;
        r          = item_row(has, rd);
        r.pinned   = 1'b1;
        r.pin_code = code;
        r.pin_ovf  = ovf;
        return r;
    endfunction

    // Random reading: mostly values sized to fit the tubes, plus noise
    function automatic ddsp_pkg::in_item_t make_reading();
        ddsp_pkg::in_item_t it;
        logic [63:0]        v;
        logic [127:0]       w;
        int                 k;
        int                 n;
        k            = $urandom_range(0, 99);
        n            = tubes_shown();
        it.has_value = (k >= 6);
        it.reading   = {$urandom, $urandom};
        if (k >= 16 && k < 22)
            it.reading = it.reading & 64'hFFFF;          // fraction only: rounding edge
        else if (k >= 22)
        begin
            v = {$urandom, $urandom} % ten_pow($urandom_range(1, n));
            if (k >= 92)
                v = ten_pow(n) - 64'(k % 2);              // just fits or just overflows
            w = (({64'd0, v} << 16) + 128'($urandom_range(0, 65535)))
                / {64'd0, ten_pow(int'(places_sh))};
            it.reading = w[63:0];
        end
        return it;
    endfunction

    // Offer one reading; start stays high on return so a following item can go
    // back to back. Expectations are queued at the edge that takes the item.
    task automatic send_reading(input ddsp_pkg::in_item_t it, input bit pinned,
                                input logic [ddsp_pkg::CODE_W-1:0] code, input bit ovf);
        ddsp_pkg::out_item_t t;
        int                  n;
        start   <= 1'b1;
        operand <= it;
        do
            @(posedge clk);
        while (busy);
        if (pinned)
        begin
            n = tubes_shown();
            for (int i = 0; i < n; i++)
            begin
                t.position   = 4'(i);
                t.tube_code  = code;
                t.overflowed = ovf;
                t.last_digit = (i == n - 1);
                pending_tubes.push_back(t);
            end
        end
        else
            predict_tubes(it);
    endtask

    // Registers change only with nothing in flight
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_tubes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ddsp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [ddsp_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        // bits above each register's width are dropped
        unique case (idx)
            ddsp_pkg::REG_DIGIT_COUNT:    count_sh  = data;
            ddsp_pkg::REG_SHOW_ZEROS:     zeros_sh  = data[0];
            ddsp_pkg::REG_DECIMAL_PLACES: places_sh = data[ddsp_pkg::PLACES_W-1:0];
            default:                      ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Tube checker: every strobe must match the oldest owed tube
    always @(posedge clk)
    begin : tube_check
        ddsp_pkg::out_item_t want;
        if (rst_n && result_valid)
        begin
            if (pending_tubes.size() == 0)
                report_mismatch("tube with nothing pending", 64'(result.position), 64'd0);
            else
            begin
                want = pending_tubes.pop_front();
                if (result.position !== want.position)
                    report_mismatch("position", 64'(result.position), 64'(want.position));
                if (result.tube_code !== want.tube_code)
                    report_mismatch("tube_code", 64'(result.tube_code), 64'(want.tube_code));
                if (result.overflowed !== want.overflowed)
                    report_mismatch("overflowed", 64'(result.overflowed),
                                    64'(want.overflowed));
                if (result.last_digit !== want.last_digit)
                    report_mismatch("last_digit", 64'(result.last_digit),
                                    64'(want.last_digit));
            end
        end
    end

    // Watchdog: any handshake or tube counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int burst_left;
        int gap;
        int drain_cycles;
        int pick;
        logic [ddsp_pkg::CFG_DATA_W-1:0] count_val;

        // After reset: one tube, blanking on, no scaling
        directed_rows.push_back(pinned_row(1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
                                           ddsp_pkg::TUBE_BLANK, 1'b0));
        directed_rows.push_back(pinned_row(1'b1, 64'h0, 4'd0, 1'b0));       // lone zero shown
        directed_rows.push_back(pinned_row(1'b1, 64'h9_0000, 4'd9, 1'b0));
        directed_rows.push_back(pinned_row(1'b1, 64'h7FFF, 4'd0, 1'b0));    // just under half
        directed_rows.push_back(pinned_row(1'b1, 64'h8000, 4'd1, 1'b0));    // half rounds up
        directed_rows.push_back(pinned_row(1'b1, 64'hA_0000, ddsp_pkg::TUBE_BLANK, 1'b1));
        directed_rows.push_back(pinned_row(1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
                                           ddsp_pkg::TUBE_BLANK, 1'b1));
        // All sixteen tubes
        directed_rows.push_back(cfg_row(ddsp_pkg::REG_DIGIT_COUNT, 5'd16));
        directed_rows.push_back(item_row(1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
        directed_rows.push_back(item_row(1'b1, 64'h0));
        directed_rows.push_back(item_row(1'b1, 64'h00FF_FFFF_FFFF_7FFF));
        // Seven places, upper data bits set
        directed_rows.push_back(cfg_row(ddsp_pkg::REG_DECIMAL_PLACES, 5'b11111));
        directed_rows.push_back(pinned_row(1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
                                           ddsp_pkg::TUBE_BLANK, 1'b1));
        directed_rows.push_back(item_row(1'b1, 64'h1));
        directed_rows.push_back(item_row(1'b1, 64'h3B9A_C9FF_0000));        // sixteen digits
        directed_rows.push_back(pinned_row(1'b1, 64'h3B9A_CA00_0000, ddsp_pkg::TUBE_BLANK,
                                           1'b1));
        // Leading zeros shown
        directed_rows.push_back(cfg_row(ddsp_pkg::REG_SHOW_ZEROS, 5'b00001));
        directed_rows.push_back(item_row(1'b1, 64'h1_0000));
        directed_rows.push_back(pinned_row(1'b0, 64'h0, ddsp_pkg::TUBE_BLANK, 1'b0));
        // Zero count acts as one tube
        directed_rows.push_back(cfg_row(ddsp_pkg::REG_DIGIT_COUNT, 5'd0));
        directed_rows.push_back(cfg_row(ddsp_pkg::REG_DECIMAL_PLACES, 5'b11000));
        directed_rows.push_back(item_row(1'b1, 64'h3_0000));
        directed_rows.push_back(pinned_row(1'b1, 64'hA_0000, ddsp_pkg::TUBE_BLANK, 1'b1));
        // Oversize count clamps to sixteen; zero flag with upper bits set
        directed_rows.push_back(cfg_row(ddsp_pkg::REG_DIGIT_COUNT, 5'd31));
        directed_rows.push_back(cfg_row(ddsp_pkg::REG_SHOW_ZEROS, 5'b11110));
        directed_rows.push_back(item_row(1'b1, 64'h1234_5678));
        // Write to the unmapped index changes nothing
        directed_rows.push_back(cfg_row(UNUSED_REG, 5'($urandom)));
        directed_rows.push_back(item_row(1'b1, {$urandom, $urandom}));
        directed_rows.push_back(cfg_row(ddsp_pkg::REG_DECIMAL_PLACES, 5'd6));
        directed_rows.push_back(item_row(1'b1, 64'h1_0000));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end
            else
                send_reading(directed_rows[i].item, directed_rows[i].pinned,
                             directed_rows[i].pin_code, directed_rows[i].pin_ovf);
        end

        // Random phases, each under a fresh register setting
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_idle();
            pick = $urandom_range(0, 9);
            if (pick == 0)
                count_val = 5'd1;
            else if (pick == 1)
                count_val = 5'd16;
            else if (pick == 2)
                count_val = 5'd0;
            else if (pick == 3)
                count_val = 5'($urandom_range(17, 31));
            else
                count_val = 5'($urandom_range(1, 16));
            write_reg(ddsp_pkg::REG_DIGIT_COUNT, count_val);
            write_reg(ddsp_pkg::REG_SHOW_ZEROS, 5'($urandom));
            write_reg(ddsp_pkg::REG_DECIMAL_PLACES, 5'($urandom));
            if ($urandom_range(0, 3) == 0)
                write_reg(UNUSED_REG, 5'($urandom));

            burst_left = $urandom_range(1, 20);
            for (int j = 0; j < PHASE_ITEMS; j++)
            begin
                if (burst_left == 0)
                begin
                    // gap between bursts, now and then a long one
                    start <= 1'b0;
                    gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 45)
                                                      : $urandom_range(1, 5);
                    repeat (gap) @(posedge clk);
                    burst_left = $urandom_range(1, 20);
                end
                send_reading(make_reading(), 1'b0, '0, 1'b0);
                burst_left--;
            end
        end

        start <= 1'b0;
        drain_cycles = 0;
        while (pending_tubes.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_tubes.size() != 0)
            report_mismatch("tubes never emitted", 64'(pending_tubes.size()), 64'd0);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ddsp_pkg.sv
sv/ddsp_scale.sv
sv/ddsp_cell.sv
sv/ddsp_conv.sv
sv/ddsp_emit.sv
sv/decimal_digit_display_splitter_top.sv
sim/decimal_digit_display_splitter_top_tb.sv
